// ----- sv/i2rd_pkg.sv -----
// Shared constants, types and the digit-to-ASCII mapping for the radix
// digit converter. No dependencies; imported by the divider and the top level.
package i2rd_pkg;

  localparam int VALUE_WIDTH = 31;
  localparam int BASE_W      = 5;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 7;
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W       = $clog2(VALUE_WIDTH);

  localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

  localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = 4'd9;
  localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'd48;
  // 'A' minus ten, so that a digit value of ten maps to 'A'.
  localparam logic [CHAR_W-1:0]  ASCII_LETTER  = 7'd55;

  typedef struct packed {
    logic busy;
    logic done;
    logic quot_zero;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W - DIGIT_W){1'b0}}, d};
    if (d <= DIGIT_MAX_DEC) begin
      return ASCII_ZERO + ext;
    end
    return ASCII_LETTER + ext;
  endfunction

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) begin
      return BASE_MIN;
    end
    if (b > BASE_MAX) begin
      return BASE_MAX;
    end
    return b;
  endfunction

endpackage

// ----- sv/i2rd_divider.sv -----
// Bit-serial restoring divider of a VALUE_WIDTH-bit dividend by a base of
// 2 to 16, one quotient bit per cycle. Depends on i2rd_pkg.
module i2rd_divider import i2rd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [BASE_W-1:0]      base,
  output div_stat_t              stat,
  output logic [VALUE_WIDTH-1:0] quotient,
  output logic [DIGIT_W-1:0]     remainder
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] quot_r, quot_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;

  logic [BASE_W-1:0] trial;
  logic [BASE_W-1:0] diff;
  logic              ge;

  // The partial remainder is below the base, so it fits in four bits; the
  // trial value with the next dividend bit needs five.
  assign trial = {rem_r, quot_r[VALUE_WIDTH-1]};
  assign ge    = (trial >= base);
  assign diff  = trial - base;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(VALUE_WIDTH);
      quot_nxt = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      quot_nxt = {quot_r[VALUE_WIDTH-2:0], ge};
      rem_nxt  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
  end

  assign stat.busy      = busy_r;
  assign stat.done      = done_r;
  assign stat.quot_zero = (quot_r == '0);
  assign quotient       = quot_r;
  assign remainder      = rem_r;

endmodule

// ----- sv/integer_to_radix_digits.sv -----
// Top level of the radix digit converter: sequencer, digit store and output
// register around the shared serial divider. Depends on i2rd_pkg, i2rd_divider.
//
// Usage. The input channel (in_valid, in_ready, in_value) takes one unsigned
// integer per item. The block writes it in the base held in the target_base
// register and gives one output item per digit on out_valid, out_ready,
// out_digit_char and out_last_digit, most significant digit first, as ASCII
// '0'-'9' and 'A'-'F'. The least significant digit carries out_last_digit.
// A zero gives the single digit '0'. The register is written through
// cfg_valid, cfg_ready and cfg_target_base; it resets to 10, and values below
// 2 or above 16 act as 2 or 16.
// Timing. One shared divider produces one quotient bit per cycle, and each
// digit takes a full division of the current quotient. The digits of an item
// are found one after another and then leave through the output register.
// in_ready is low from acceptance until the last digit has moved into the
// output register.
// Stalls. A stalled receiver holds the digit in the output register and the
// remaining digits wait behind it. Only once the last digit is in the output
// register may a new item be taken while that digit still waits.
// Reset. Synchronous reset drops all valids, empties the sequencer and sets
// target_base back to 10.
module integer_to_radix_digits import i2rd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      out_digit_char,
  output logic                   out_last_digit,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [BASE_W-1:0]      cfg_target_base
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [BASE_W-1:0]  target_base_r;
  logic [BASE_W-1:0]  base_r;
  logic [CNT_W-1:0]   ndig_r;
  logic [IDX_W-1:0]   rd_r;
  logic [DIGIT_W-1:0] digits_r [VALUE_WIDTH];

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic                   in_accept;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  div_stat_t              div_stat;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [DIGIT_W-1:0]     div_rem;
  logic                   digit_done;
  logic                   emit_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // A finished digit is stored; when the quotient is not yet zero the
  // divider is restarted at once on that quotient.
  assign digit_done   = (state_r == ST_DIVIDE) && div_stat.done;
  assign div_start    = in_accept || (digit_done && !div_stat.quot_zero);
  assign div_dividend = in_accept ? in_value : div_quot;

  // In the emit phase the output register is refilled whenever it is empty or being emptied.
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  i2rd_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .base      (in_accept ? clamp_base(target_base_r) : base_r),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (digit_done && div_stat.quot_zero) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load && (rd_r == '0)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      target_base_r <= BASE_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        target_base_r <= cfg_target_base;
      end
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    if (in_accept) begin
      base_r <= clamp_base(target_base_r);
      ndig_r <= '0;
    end else if (digit_done) begin
      digits_r[ndig_r[IDX_W-1:0]] <= div_rem;
      ndig_r <= ndig_r + 1'b1;
      // The digit just stored is the most significant one so far; the last one stored goes out first.
      rd_r   <= ndig_r[IDX_W-1:0];
    end else if (emit_load) begin
      rd_r <= rd_r - 1'b1;
    end

    if (emit_load) begin
      out_char_r <= digit_to_ascii(digits_r[rd_r]);
      out_last_r <= (rd_r == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

`ifndef SYNTHESIS
  // The divider is only restarted once the previous division has finished.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // A division in flight always belongs to the divide phase.
  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> (state_r == ST_DIVIDE))
    else $error("divider busy outside the divide phase");

  // Loading the least significant digit ends the item.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && (rd_r == '0)) |=> (state_r == ST_IDLE) && out_valid && out_last_digit)
    else $error("last digit did not end the item");

  // No more digits are stored than the value has bits.
  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    digit_done |-> (ndig_r < CNT_W'(VALUE_WIDTH)))
    else $error("digit store overflow");
`endif

endmodule
